// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/rgbm_pkg.sv -----
// Package: widths and constants of the RGBM pixel encoder.
`timescale 1ns / 1ps

package rgbm_pkg;

	// field widths
	localparam int IN_W   = 32;
	localparam int CH_W   = IN_W - 1;          // magnitude of a clamped channel
	localparam int BYTE_W = 8;
	localparam int K_W    = 4;

	// scale factor 255*255 (the factor 255 is a shift and subtract)
	localparam int                  SCALE2_W = 16;
	localparam logic [SCALE2_W-1:0] SCALE2   = 16'd65025;

	// products of a channel with the scale factors
	localparam int NUM_W  = CH_W + SCALE2_W;   // c * 65025
	localparam int C255_W = CH_W + BYTE_W;     // c * 255

	// range register
	localparam logic [K_W-1:0] K_MIN   = 4'd2;
	localparam logic [K_W-1:0] K_RESET = 4'd2;
	localparam int             K_MAX   = 15;

	// multiplier limits and saturated byte
	localparam logic [BYTE_W-1:0] M_MIN    = 8'd1;
	localparam logic [BYTE_W-1:0] M_MAX    = 8'd255;
	localparam logic [BYTE_W-1:0] SAT_BYTE = 8'd255;

	// divider: one quotient bit per stage, remainder below 256*M
	localparam int DIV_STAGES = BYTE_W;
	localparam int REM_W      = 16;

	// pipeline: two lane stages (merge beside the second), prep stage, divider stages
	localparam int NUM_STAGES = 3 + DIV_STAGES;

endpackage

// ----- rtl/core/rgbm_pix_if.sv -----
// Interface: pixel input channel (three signed Q channels).
`timescale 1ns / 1ps

interface rgbm_pix_if;
	logic                             valid;
	logic                             ready;
	logic signed [rgbm_pkg::IN_W-1:0] red_in;
	logic signed [rgbm_pkg::IN_W-1:0] green_in;
	logic signed [rgbm_pkg::IN_W-1:0] blue_in;

	modport source (output valid, red_in, green_in, blue_in, input ready);
	modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

// ----- rtl/core/rgbm_enc_if.sv -----
// Interface: encoded RGBM output channel.
`timescale 1ns / 1ps

interface rgbm_enc_if;
	logic                          valid;
	logic                          ready;
	logic [rgbm_pkg::BYTE_W-1:0]   red_byte;
	logic [rgbm_pkg::BYTE_W-1:0]   green_byte;
	logic [rgbm_pkg::BYTE_W-1:0]   blue_byte;
	logic [rgbm_pkg::BYTE_W-1:0]   multiplier_byte;

	modport source (output valid, red_byte, green_byte, blue_byte, multiplier_byte,
		input ready);
	modport sink   (input valid, red_byte, green_byte, blue_byte, multiplier_byte,
		output ready);
endinterface

// ----- rtl/core/rgbm_cfg_if.sv -----
// Interface: configuration write channel for the range register.
`timescale 1ns / 1ps

interface rgbm_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [rgbm_pkg::K_W-1:0]   range_log2;

	modport source (output valid, range_log2, input ready);
	modport sink   (input valid, range_log2, output ready);
endinterface

// ----- rtl/core/rgbm_lane_front.sv -----
// Lane front end: clamp, scale by 255 and 255^2, pre-shift the numerator.
`timescale 1ns / 1ps

module rgbm_lane_front #(
	parameter  int FRAC_BITS = 16,
	localparam int SH_W      = $clog2(FRAC_BITS + rgbm_pkg::K_MAX + 1),
	localparam int B_W       = rgbm_pkg::NUM_W - FRAC_BITS - 1
) (
	input  logic                               clk,
	input  logic [1:0]                         en,       // stage loads s2..s1
	input  logic signed [rgbm_pkg::IN_W-1:0]   chan,
	input  logic [SH_W-1:0]                    sh_m1,    // total shift minus one
	output logic [rgbm_pkg::C255_W-1:0]        c255_s1,
	output logic [B_W-1:0]                     b_s2
);

	logic [rgbm_pkg::CH_W-1:0]   mag;
	logic [rgbm_pkg::NUM_W-1:0]  num;
	logic [rgbm_pkg::C255_W-1:0] c255;
	logic [rgbm_pkg::NUM_W-1:0]  num_s1;

	// negatives clamp to zero
	assign mag = chan[rgbm_pkg::IN_W-1] ? '0 : chan[rgbm_pkg::CH_W-1:0];

	// c * 65025 on one multiplier, c * 255 as shift and subtract
	assign num  = rgbm_pkg::NUM_W'(mag) * rgbm_pkg::NUM_W'(rgbm_pkg::SCALE2);
	assign c255 = {mag, {rgbm_pkg::BYTE_W{1'b0}}} - rgbm_pkg::C255_W'(mag);

	// stage 1
	always_ff @(posedge clk) begin
		if (en[0]) begin
			num_s1  <= num;
			c255_s1 <= c255;
		end
	end

	// stage 2: floor(2*num / 2^shift)
	always_ff @(posedge clk) begin
		if (en[1]) begin
			b_s2 <= B_W'(num_s1 >> sh_m1);
		end
	end

endmodule

// ----- rtl/core/rgbm_merge.sv -----
// Merge stage: peak over the three lanes and the shared multiplier M.
`timescale 1ns / 1ps

module rgbm_merge #(
	parameter  int FRAC_BITS = 16,
	localparam int SH_W      = $clog2(FRAC_BITS + rgbm_pkg::K_MAX + 1),
	localparam int SUM_W     = rgbm_pkg::C255_W + 1
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [rgbm_pkg::C255_W-1:0]        red_c255,
	input  logic [rgbm_pkg::C255_W-1:0]        green_c255,
	input  logic [rgbm_pkg::C255_W-1:0]        blue_c255,
	input  logic [SH_W-1:0]                    shift,
	output logic [rgbm_pkg::BYTE_W-1:0]        m_s2
);

	logic [rgbm_pkg::C255_W-1:0] peak_rg;
	logic [rgbm_pkg::C255_W-1:0] peak;
	logic [SUM_W-1:0]            round_up;
	logic [SUM_W-1:0]            ceil_q;
	logic [rgbm_pkg::BYTE_W-1:0] m_next;

	// largest scaled channel
	assign peak_rg = (green_c255 > red_c255) ? green_c255 : red_c255;
	assign peak    = (blue_c255 > peak_rg) ? blue_c255 : peak_rg;

	// ceiling of peak / 2^shift
	assign round_up = (SUM_W'(1) << shift) - SUM_W'(1);
	assign ceil_q   = (SUM_W'(peak) + round_up) >> shift;

	// hold M between 1 and 255
	always_comb begin
		priority if (ceil_q == '0) begin
			m_next = rgbm_pkg::M_MIN;
		end else if (ceil_q > SUM_W'(rgbm_pkg::M_MAX)) begin
			m_next = rgbm_pkg::M_MAX;
		end else begin
			m_next = ceil_q[rgbm_pkg::BYTE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2 <= m_next;
		end
	end

endmodule

// ----- rtl/core/rgbm_div_lane.sv -----
// Lane back end: rounding, saturation test and an 8-stage divide by M.
`timescale 1ns / 1ps

module rgbm_div_lane #(
	parameter  int FRAC_BITS = 16,
	localparam int B_W       = rgbm_pkg::NUM_W - FRAC_BITS - 1,
	localparam int DS        = rgbm_pkg::DIV_STAGES,
	localparam int REM_W     = rgbm_pkg::REM_W,
	localparam int BW        = rgbm_pkg::BYTE_W
) (
	input  logic                     clk,
	input  logic [DS:0]              en,       // stage loads, s3 at bit 0
	input  logic [B_W-1:0]           b_s2,
	input  logic [DS:0][BW-1:0]      m_feed,   // M as seen by each stage's input
	output logic [BW-1:0]            byte_out
);

	logic [B_W:0]     t_sum;
	logic [REM_W-1:0] m255;
	logic             sat;

	logic [REM_W-1:0] rem_s [3:DS+2];
	logic [BW-1:0]    quo_s [3:DS+3];
	logic             sat_s [3:DS+3];

	// T = (B + M) / 2, saturate when floor(num / 2^shift) >= 255*M
	assign t_sum = {1'b0, b_s2} + (B_W+1)'(m_feed[0]);
	assign m255  = {m_feed[0], {BW{1'b0}}} - REM_W'(m_feed[0]);
	assign sat   = b_s2[B_W-1:1] >= (B_W-1)'(m255);

	// stage 3: below saturation T < 256*M fits the remainder width
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[3] <= t_sum[REM_W:1];
			quo_s[3] <= '0;
			sat_s[3] <= sat;
		end
	end

	// restoring division, one quotient bit per stage, MSB first
	for (genvar j = 0; j < DS; j++) begin : g_div
		logic [REM_W-1:0] dvs;
		logic             ge;

		assign dvs = REM_W'(m_feed[j+1]) << (DS - 1 - j);
		assign ge  = rem_s[j+3] >= dvs;

		always_ff @(posedge clk) begin
			if (en[j+1]) begin
				quo_s[j+4] <= quo_s[j+3] | (BW'(ge) << (DS - 1 - j));
				sat_s[j+4] <= sat_s[j+3];
			end
		end

		if (j < DS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en[j+1]) begin
					rem_s[j+4] <= ge ? (rem_s[j+3] - dvs) : rem_s[j+3];
				end
			end
		end
	end

	assign byte_out = sat_s[DS+3] ? rgbm_pkg::SAT_BYTE : quo_s[DS+3];

endmodule

// ----- rtl/core/rgbm_pixel_encoder_core.sv -----
// Top level: RGBM pixel encoder with three channel lanes and a shared merge.
`timescale 1ns / 1ps
//
// Encodes one HDR pixel (signed fixed-point red, green, blue) into RGBM bytes.
// pixel:   item in, accepted when pixel.valid and pixel.ready are both high.
// encoded: item out, taken when encoded.valid and encoded.ready are both high.
// cfg:     writes range_log2 (values 0 and 1 act as 2); always ready. Write it
//          only while no item is in flight.
// Depth: 11 stages; the item is offered on encoded.valid from the last one.
// Throughput: one item per cycle unless stalled. Each lane runs a fully
//          pipelined eight-stage divide by M (one quotient bit per stage) after
//          two scaling stages (the merge finds the peak and M beside the second)
//          and a rounding stage.
// Stall: when encoded.ready is low, stages hold; empty stages in the pipe
//          still load, so input is taken until all 11 stages are full.
// Reset: arst_n clears all stage valid bits and sets range_log2 to 2.
// Results leave in acceptance order, one per item.
//
module rgbm_pixel_encoder_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	rgbm_pix_if.sink      pixel,
	rgbm_enc_if.source    encoded,
	rgbm_cfg_if.sink      cfg
);

	localparam int SH_W = $clog2(FRAC_BITS + rgbm_pkg::K_MAX + 1);
	localparam int B_W  = rgbm_pkg::NUM_W - FRAC_BITS - 1;
	localparam int NS   = rgbm_pkg::NUM_STAGES;
	localparam int DS   = rgbm_pkg::DIV_STAGES;
	localparam int BW   = rgbm_pkg::BYTE_W;

	logic [rgbm_pkg::K_W-1:0] range_log2_q;
	logic [rgbm_pkg::K_W-1:0] k_eff;
	logic [SH_W-1:0]          shift;
	logic [SH_W-1:0]          sh_m1;

	logic [NS:1]              valid_s;
	wire  [NS:1]              en;

	logic [rgbm_pkg::C255_W-1:0] red_c255_s1;
	logic [rgbm_pkg::C255_W-1:0] green_c255_s1;
	logic [rgbm_pkg::C255_W-1:0] blue_c255_s1;
	logic [B_W-1:0]              red_b_s2;
	logic [B_W-1:0]              green_b_s2;
	logic [B_W-1:0]              blue_b_s2;

	logic [BW-1:0]           m_s2;
	logic [BW-1:0]           m_sn [3:NS];
	logic [DS:0][BW-1:0]     m_feed;

	// range register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_log2_q <= rgbm_pkg::K_RESET;
		end else if (cfg.valid) begin
			range_log2_q <= cfg.range_log2;
		end
	end

	assign k_eff = (range_log2_q < rgbm_pkg::K_MIN) ? rgbm_pkg::K_MIN : range_log2_q;
	assign shift = SH_W'(FRAC_BITS) + SH_W'(k_eff);
	assign sh_m1 = shift - SH_W'(1);

	// stage loads: a stage loads when empty or when the next one loads
	assign en[NS] = !valid_s[NS] || encoded.ready;
	for (genvar j = 1; j < NS; j++) begin : g_en
		assign en[j] = !valid_s[j] || en[j+1];
	end

	assign pixel.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[1]) begin
				valid_s[1] <= pixel.valid;
			end
			for (int j = 2; j <= NS; j++) begin
				if (en[j]) begin
					valid_s[j] <= valid_s[j-1];
				end
			end
		end
	end

	// channel lanes, front end
	rgbm_lane_front #(.FRAC_BITS(FRAC_BITS)) u_front_red (
		.clk(clk), .en(en[2:1]), .chan(pixel.red_in), .sh_m1(sh_m1),
		.c255_s1(red_c255_s1), .b_s2(red_b_s2)
	);
	rgbm_lane_front #(.FRAC_BITS(FRAC_BITS)) u_front_green (
		.clk(clk), .en(en[2:1]), .chan(pixel.green_in), .sh_m1(sh_m1),
		.c255_s1(green_c255_s1), .b_s2(green_b_s2)
	);
	rgbm_lane_front #(.FRAC_BITS(FRAC_BITS)) u_front_blue (
		.clk(clk), .en(en[2:1]), .chan(pixel.blue_in), .sh_m1(sh_m1),
		.c255_s1(blue_c255_s1), .b_s2(blue_b_s2)
	);

	// shared multiplier from the lane peaks
	rgbm_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
		.clk(clk), .en(en[2]),
		.red_c255(red_c255_s1), .green_c255(green_c255_s1), .blue_c255(blue_c255_s1),
		.shift(shift), .m_s2(m_s2)
	);

	// M travels beside the divider stages
	always_ff @(posedge clk) begin
		if (en[3]) begin
			m_sn[3] <= m_s2;
		end
		for (int j = 4; j <= NS; j++) begin
			if (en[j]) begin
				m_sn[j] <= m_sn[j-1];
			end
		end
	end

	always_comb begin
		m_feed[0] = m_s2;
		for (int j = 1; j <= DS; j++) begin
			m_feed[j] = m_sn[j+2];
		end
	end

	// channel lanes, divider back end
	rgbm_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_red (
		.clk(clk), .en(en[NS:3]), .b_s2(red_b_s2), .m_feed(m_feed),
		.byte_out(encoded.red_byte)
	);
	rgbm_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_green (
		.clk(clk), .en(en[NS:3]), .b_s2(green_b_s2), .m_feed(m_feed),
		.byte_out(encoded.green_byte)
	);
	rgbm_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_blue (
		.clk(clk), .en(en[NS:3]), .b_s2(blue_b_s2), .m_feed(m_feed),
		.byte_out(encoded.blue_byte)
	);

	assign encoded.valid           = valid_s[NS];
	assign encoded.multiplier_byte = m_sn[NS];

endmodule

// ----- rtl/core/rgbm_chk.sv -----
// Checker on the encoded output channel, bound to the core.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgbm_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          enc_valid,
	input logic                          enc_ready,
	input logic [rgbm_pkg::BYTE_W-1:0]   red_byte,
	input logic [rgbm_pkg::BYTE_W-1:0]   green_byte,
	input logic [rgbm_pkg::BYTE_W-1:0]   blue_byte,
	input logic [rgbm_pkg::BYTE_W-1:0]   multiplier_byte
);

	logic                            stalled;
	logic                            m_above_one;
	logic                            peak_msb;
	logic [4*rgbm_pkg::BYTE_W-1:0]   enc_word;

	assign stalled     = enc_valid && !enc_ready;
	assign m_above_one = enc_valid && (multiplier_byte != rgbm_pkg::M_MIN);
	assign peak_msb    = red_byte[7] || green_byte[7] || blue_byte[7];
	assign enc_word    = {red_byte, green_byte, blue_byte, multiplier_byte};

	// M is never zero
	`ASSERT_IMPL(a_m_nonzero, clk, arst_n, enc_valid, multiplier_byte != 8'd0)

	// with M above one the peak channel encodes to at least half scale
	`ASSERT_IMPL(a_peak_half, clk, arst_n, m_above_one, peak_msb)

	// a stalled item stays offered
	`ASSERT_NEXT(a_valid_hold, clk, arst_n, stalled, enc_valid)

	// and keeps its payload
	`ASSERT_NEXT(a_data_hold, clk, arst_n, stalled, $stable(enc_word))

endmodule

bind rgbm_pixel_encoder_core rgbm_chk u_rgbm_chk (
	.clk(clk),
	.arst_n(arst_n),
	.enc_valid(encoded.valid),
	.enc_ready(encoded.ready),
	.red_byte(encoded.red_byte),
	.green_byte(encoded.green_byte),
	.blue_byte(encoded.blue_byte),
	.multiplier_byte(encoded.multiplier_byte)
);

// ----- sim/tb.sv -----
// Testbench for the RGBM pixel encoder: random and corner-case pixels checked against a predictor.
`timescale 1ns / 1ps

module tb;

	localparam int          FRAC       = 16;
	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned LONG_HOLD  = 48;
	localparam int unsigned PHASE_LEN  = 98;
	localparam int unsigned MAX_PRINTS = 20;

	// one accepted pixel and the bytes it should encode to
	typedef struct {
		logic signed [rgbm_pkg::IN_W-1:0] red;
		logic signed [rgbm_pkg::IN_W-1:0] green;
		logic signed [rgbm_pkg::IN_W-1:0] blue;
		logic [rgbm_pkg::K_W-1:0]         k;
		logic [rgbm_pkg::BYTE_W-1:0]      red_b;
		logic [rgbm_pkg::BYTE_W-1:0]      green_b;
		logic [rgbm_pkg::BYTE_W-1:0]      blue_b;
		logic [rgbm_pkg::BYTE_W-1:0]      mult_b;
	} rgbm_item_t;

	// tracks the range register and the encodings still owed by the block
	class rgbm_scoreboard;
		int unsigned               frac_bits;
		logic [rgbm_pkg::K_W-1:0]  range_k;
		rgbm_item_t                owed_q[$];
		int unsigned               errors;
		int unsigned               seen;

		function new(int unsigned frac);
			frac_bits = frac;
			range_k   = rgbm_pkg::K_RESET;
			errors    = 0;
			seen      = 0;
		endfunction

		function void set_range(logic [rgbm_pkg::K_W-1:0] v);
			range_k = v;
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction

		// negative channels count as zero
		function longint unsigned magnitude(logic signed [rgbm_pkg::IN_W-1:0] v);
			if (v[rgbm_pkg::IN_W-1])
				return 0;
			return 64'(v[rgbm_pkg::IN_W-2:0]);
		endfunction

		// round(c * 255^2 / den), ties up, saturated
		function logic [rgbm_pkg::BYTE_W-1:0] colour_byte(longint unsigned c,
			longint unsigned den);
			longint unsigned num;
			num = c * 64'd65025;
			if (num >= 64'd255 * den)
				return rgbm_pkg::SAT_BYTE;
			return rgbm_pkg::BYTE_W'((2 * num + den) / (2 * den));
		endfunction

		// predict the RGBM bytes of one accepted pixel
		function void note_pixel(logic signed [rgbm_pkg::IN_W-1:0] r,
			logic signed [rgbm_pkg::IN_W-1:0] g, logic signed [rgbm_pkg::IN_W-1:0] b);
			rgbm_item_t                it;
			logic [rgbm_pkg::K_W-1:0]  kk;
			int unsigned               sh;
			longint unsigned           cr, cg, cb, peak, m, den;
			kk   = (range_k < rgbm_pkg::K_MIN) ? rgbm_pkg::K_MIN : range_k;
			sh   = frac_bits + kk;
			cr   = magnitude(r);
			cg   = magnitude(g);
			cb   = magnitude(b);
			peak = cr;
			if (cg > peak)
				peak = cg;
			if (cb > peak)
				peak = cb;
			m = (peak * 64'd255 + (64'd1 << sh) - 1) >> sh;
			if (m < 64'(rgbm_pkg::M_MIN))
				m = 64'(rgbm_pkg::M_MIN);
			if (m > 64'(rgbm_pkg::M_MAX))
				m = 64'(rgbm_pkg::M_MAX);
			den        = m << sh;
			it.red     = r;
			it.green   = g;
			it.blue    = b;
			it.k       = range_k;
			it.red_b   = colour_byte(cr, den);
			it.green_b = colour_byte(cg, den);
			it.blue_b  = colour_byte(cb, den);
			it.mult_b  = rgbm_pkg::BYTE_W'(m);
			owed_q.insert(owed_q.size(), it);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("%s", msg);
		endtask

		// compare one encoded item with the oldest prediction
		task check(logic [rgbm_pkg::BYTE_W-1:0] rb, logic [rgbm_pkg::BYTE_W-1:0] gb,
			logic [rgbm_pkg::BYTE_W-1:0] bb, logic [rgbm_pkg::BYTE_W-1:0] mb);
			rgbm_item_t it;
			string      px;
			if (owed_q.size() == 0) begin
				report($sformatf("mismatch: unexpected item %0d %0d %0d m=%0d",
					rb, gb, bb, mb));
				return;
			end
			it = owed_q.pop_front();
			px = $sformatf("item %0d (%h %h %h k=%0d)", seen, it.red, it.green, it.blue,
				it.k);
			seen++;
			if (rb !== it.red_b)
				report($sformatf("mismatch: %s red_byte %0d, want %0d", px, rb, it.red_b));
			if (gb !== it.green_b)
				report($sformatf("mismatch: %s green_byte %0d, want %0d", px, gb, it.green_b));
			if (bb !== it.blue_b)
				report($sformatf("mismatch: %s blue_byte %0d, want %0d", px, bb, it.blue_b));
			if (mb !== it.mult_b)
				report($sformatf("mismatch: %s multiplier_byte %0d, want %0d", px, mb, it.mult_b));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	rgbm_pix_if pix_ch ();
	rgbm_enc_if enc_ch ();
	rgbm_cfg_if cfg_ch ();

	rgbm_pixel_encoder_core #(
		.FRAC_BITS (FRAC)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pix_ch),
		.encoded (enc_ch),
		.cfg     (cfg_ch)
	);

	rgbm_scoreboard sb = new(FRAC);

	// requests for a long output hold, raised by the stimulus
	int unsigned              hold_req;
	logic [rgbm_pkg::K_W-1:0] cur_k;

	always #1 clk = ~clk;

	// sample all handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.set_range(cfg_ch.range_log2);
			if (pix_ch.valid && pix_ch.ready)
				sb.note_pixel(pix_ch.red_in, pix_ch.green_in, pix_ch.blue_in);
			if (enc_ch.valid && enc_ch.ready)
				sb.check(enc_ch.red_byte, enc_ch.green_byte, enc_ch.blue_byte,
					enc_ch.multiplier_byte);
		end
	end

	// watchdog: too long with no item moving on any channel
	int unsigned idle_cycles = 0;
	always @(posedge clk) begin
		if ((pix_ch.valid && pix_ch.ready) || (enc_ch.valid && enc_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// output side: runs of random stall patterns, plus long holds on request
	initial begin : out_side
		int unsigned run_len;
		int unsigned style;
		int unsigned hold_seen;
		int unsigned n;
		hold_seen = 0;
		n = 0;
		enc_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				enc_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				style   = $urandom_range(0, 3);
				run_len = $urandom_range(4, 40);
				repeat (run_len) begin
					n++;
					case (style)
						0: enc_ch.ready <= 1'b1;
						1: enc_ch.ready <= ($urandom_range(0, 3) != 0);
						2: enc_ch.ready <= $urandom_range(0, 1);
						default: enc_ch.ready <= ((n % 3) != 2);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// offer one pixel and hold it until taken
	task automatic push_pixel(input logic signed [rgbm_pkg::IN_W-1:0] r,
		input logic signed [rgbm_pkg::IN_W-1:0] g,
		input logic signed [rgbm_pkg::IN_W-1:0] b);
		pix_ch.valid    <= 1'b1;
		pix_ch.red_in   <= r;
		pix_ch.green_in <= g;
		pix_ch.blue_in  <= b;
		do @(posedge clk); while (!pix_ch.ready);
	endtask

	// wait until every owed encoding has come back
	task automatic wait_drained();
		do @(negedge clk); while (sb.pending() != 0);
		@(posedge clk);
	endtask

	task automatic write_range(input logic [rgbm_pkg::K_W-1:0] v);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.range_log2 <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_k = v;
	endtask

	// one channel value, shaped around the current range
	function automatic logic signed [rgbm_pkg::IN_W-1:0] rand_channel();
		int unsigned     sh;
		longint unsigned base;
		longint unsigned mask;
		sh   = FRAC + ((cur_k < rgbm_pkg::K_MIN) ? rgbm_pkg::K_MIN : cur_k);
		mask = (64'd1 << sh) - 1;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom | 32'h8000_0000;
			2: return '0;
			3: return 32'h7fff_ffff;
			4: return $urandom_range(0, 255);
			5: begin
				// near the step where M changes
				base = (64'($urandom_range(1, 255)) << sh) / 255 + $urandom_range(0, 2) - 1;
				if (base > 64'h7fff_ffff)
					base = 64'h7fff_ffff;
				return rgbm_pkg::IN_W'(base);
			end
			6: return rgbm_pkg::IN_W'(mask + $urandom_range(0, 1000));
			default: return rgbm_pkg::IN_W'((64'($urandom) & mask) >> $urandom_range(0, 10));
		endcase
	endfunction

	// random pixels in bursts; steady means back to back
	task automatic run_phase(input int unsigned count, input bit steady);
		int unsigned sent;
		int unsigned burst;
		int unsigned i;
		sent = 0;
		while (sent < count) begin
			burst = steady ? count : $urandom_range(1, 24);
			for (i = 0; i < burst && sent < count; i++) begin
				push_pixel(rand_channel(), rand_channel(), rand_channel());
				sent++;
			end
			if (!steady && $urandom_range(0, 3) != 0) begin
				pix_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		pix_ch.valid <= 1'b0;
	endtask

	// reset, directed corners, then random phases over several ranges
	initial begin : stim
		logic [rgbm_pkg::K_W-1:0] ranges [8];
		int unsigned              p;
		ranges = '{4'd15, 4'd0, 4'd1, 4'd9, 4'd2, 4'd5, 4'd12, 4'd0};
		ranges[7] = $urandom_range(0, 15);
		hold_req          <= 0;
		cur_k             = rgbm_pkg::K_RESET;
		arst_n            <= 1'b0;
		pix_ch.valid      <= 1'b0;
		pix_ch.red_in     <= '0;
		pix_ch.green_in   <= '0;
		pix_ch.blue_in    <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.range_log2 <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners at the reset range (2^18 full scale)
		push_pixel(32'sd0, 32'sd0, 32'sd0);
		push_pixel(32'sd1, 32'sd1, 32'sd1);
		push_pixel(-32'sd1, -32'sd1, -32'sd1);
		push_pixel(32'sh8000_0000, 32'sh7fff_ffff, 32'sd0);
		push_pixel(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
		push_pixel(32'sd262144, 32'sd0, 32'sd0);
		push_pixel(32'sd262145, 32'sd5, -32'sd7);
		push_pixel(32'sd1028, 32'sd514, 32'sd0);
		push_pixel(32'sd1029, 32'sd1028, 32'sd1);
		push_pixel(32'sd65536, -32'sd65536, 32'sd32768);
		push_pixel(32'sh5555_5555, 32'sh2aaa_aaaa, 32'shaaaa_aaaa);
		push_pixel(32'sd100, 32'sd5000, 32'sd200);
		push_pixel(32'sd100, 32'sd200, 32'sd90000);
		// green lands exactly on a half step
		push_pixel(32'sd262144, 32'sd131072, 32'sd1);
		push_pixel(32'sd255, 32'sd256, 32'sd257);
		pix_ch.valid <= 1'b0;

		// random phases, each under its own range setting
		for (p = 0; p < 8; p++) begin
			wait_drained();
			write_range(ranges[p]);
			if (p == 3 || p == 6) begin
				hold_req <= hold_req + 1;
				run_phase(PHASE_LEN, 1'b1);
			end else begin
				run_phase(PHASE_LEN, 1'b0);
			end
		end

		wait_drained();
		repeat (30) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("mismatch: %0d items never came out", sb.pending()));
		if (sb.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rgbm_pkg.sv
rtl/core/rgbm_pix_if.sv
rtl/core/rgbm_enc_if.sv
rtl/core/rgbm_cfg_if.sv
rtl/core/rgbm_lane_front.sv
rtl/core/rgbm_merge.sv
rtl/core/rgbm_div_lane.sv
rtl/core/rgbm_pixel_encoder_core.sv
rtl/core/rgbm_chk.sv
sim/tb.sv
